// ===== hdl/ctls_pkg.sv =====
`default_nettype none

package ctls_pkg;

    typedef enum logic [1:0] {
        LS_CARRIER = 2'd0,
        LS_TONE    = 2'd1,
        LS_FOUND   = 2'd2,
        LS_FAILED  = 2'd3
    } lock_state_t;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_TICK10  = 2'd1,
        ACT_TICK500 = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        TK_NONE    = 2'd0,
        TK_DIGITAL = 2'd1,
        TK_TONE    = 2'd2
    } tone_kind_t;

    localparam logic [31:0] NEAR_LIMIT     = 32'd100;
    localparam logic [31:0] HALF_RANGE     = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam logic [1:0]  CARRIER_HITS   = 2'd3;
    localparam logic [1:0]  TONE_HITS      = 2'd2;
    localparam logic [1:0]  HITS_MAX       = 2'd3;
    localparam logic [5:0]  PROGRESS_LIMIT = 6'd32;
    localparam logic [5:0]  PROGRESS_MAX   = 6'd33;
    localparam logic [7:0]  NO_CODE        = 8'hFF;
    localparam logic [7:0]  DWELL_RESET    = 8'd10;

    typedef struct packed {
        logic [1:0]  action;
        logic        single_freq;
        logic [31:0] start_freq;
        logic        scan_active;
        logic        prompt_open;
        logic        counter_valid;
        logic [31:0] counter_freq;
        logic [1:0]  tone_kind;
        logic [7:0]  tone_code;
    } item_t;

    typedef struct packed {
        lock_state_t lock_state;
        logic [31:0] locked_freq;
        logic [7:0]  found_code;
        logic [1:0]  found_type;
        logic        code_valid;
        logic [5:0]  progress;
        logic        restart_counter;
        logic        arm_tone_scan;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/carrier_and_tone_lock_sequencer_top.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// s_        | in        | s_valid / s_ready  | action, single_freq, start_freq, flags,
//           |           |                    | counter_freq, tone_kind, tone_code
// m_        | out       | m_valid / m_ready  | lock_state, locked_freq, found code/type,
//           |           |                    | code_valid, progress, two pulses
// cfg_      | in        | cfg_wr_en only     | cfg_wr_data = dwell_ticks
//
// One item per cycle sustained while m_ready stays high; an item's result reaches m_ through
// the input register, then one step of compare-and-update logic into the result register.
// Reset (aresetn low at a clock edge) empties both registers, sets dwell_ticks to 10
// and puts the sequencer in carrier search at frequency all ones.
// A stall on m_ holds the result; the input register still takes an item, and s_ready
// drops only when both registers are full and m_ready is low.
`default_nettype none

module carrier_and_tone_lock_sequencer_top
    import ctls_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic        s_single_freq,
    input  wire logic [31:0] s_start_freq,
    input  wire logic        s_scan_active,
    input  wire logic        s_prompt_open,
    input  wire logic        s_counter_valid,
    input  wire logic [31:0] s_counter_freq,
    input  wire logic [1:0]  s_tone_kind,
    input  wire logic [7:0]  s_tone_code,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_lock_state,
    output logic [31:0]      m_locked_freq,
    output logic [7:0]       m_found_code,
    output logic [1:0]       m_found_type,
    output logic             m_code_valid,
    output logic [5:0]       m_progress,
    output logic             m_restart_counter,
    output logic             m_arm_tone_scan
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t step_result;
    logic    advance;

    // Move the held item through the step when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Payload: capture only on acceptance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action        <= s_action;
            in_item_reg.single_freq   <= s_single_freq;
            in_item_reg.start_freq    <= s_start_freq;
            in_item_reg.scan_active   <= s_scan_active;
            in_item_reg.prompt_open   <= s_prompt_open;
            in_item_reg.counter_valid <= s_counter_valid;
            in_item_reg.counter_freq  <= s_counter_freq;
            in_item_reg.tone_kind     <= s_tone_kind;
            in_item_reg.tone_code     <= s_tone_code;
        end
    end

    // Sequencer state and the one-step update.
    ctls_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .item        (in_item_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_lock_state      = 2'(out_result_reg.lock_state);
    assign m_locked_freq     = out_result_reg.locked_freq;
    assign m_found_code      = out_result_reg.found_code;
    assign m_found_type      = out_result_reg.found_type;
    assign m_code_valid      = out_result_reg.code_valid;
    assign m_progress        = out_result_reg.progress;
    assign m_restart_counter = out_result_reg.restart_counter;
    assign m_arm_tone_scan   = out_result_reg.arm_tone_scan;

endmodule

`default_nettype wire

// ===== hdl/ctls_core.sv =====
`default_nettype none

module ctls_core
    import ctls_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       fire,
    input  wire item_t      item,
    output result_t         result
);

    typedef struct packed {
        lock_state_t lock_state;
        logic [31:0] freq;
        logic [1:0]  hits;
        logic [7:0]  code;
        tone_kind_t  code_kind;
        logic        code_ok;
        logic [5:0]  progress;
        logic [7:0]  dwell;
        logic        single_mode;
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [7:0] dwell_ticks_reg;
    logic       restart;
    logic       arm;

    function automatic state_t clear_result(state_t s);
        state_t r;
        r           = s;
        r.code      = NO_CODE;
        r.code_kind = TK_NONE;
        r.code_ok   = 1'b0;
        r.hits      = 2'd0;
        r.progress  = 6'd0;
        return r;
    endfunction

    function automatic logic [1:0] bump(logic [1:0] h);
        return (h < HITS_MAX) ? 2'(h + 2'd1) : h;
    endfunction

    always_comb begin
        state_t      n;
        logic [31:0] diff;
        logic [31:0] span;
        logic        near;
        n       = state_reg;
        restart = 1'b0;
        arm     = 1'b0;
        diff    = item.counter_freq - state_reg.freq;
        span    = (diff > HALF_RANGE) ? (32'd0 - diff) : diff;
        near    = (span < NEAR_LIMIT);
        unique case (action_t'(item.action))
            ACT_START: begin
                n.single_mode = item.single_freq;
                if (item.single_freq) begin
                    n.lock_state = LS_TONE;
                    n.freq       = item.start_freq;
                    arm          = 1'b1;
                end else begin
                    n.lock_state = LS_CARRIER;
                    n.freq       = ALL_ONES;
                    restart      = 1'b1;
                end
                n.dwell = dwell_ticks_reg;
                n       = clear_result(n);
            end
            ACT_TICK10: begin
                if (item.scan_active) begin
                    if (state_reg.dwell != 8'd0) begin
                        n.dwell = state_reg.dwell - 8'd1;
                    end else if (!item.prompt_open) begin
                        if (state_reg.lock_state == LS_CARRIER && item.counter_valid) begin
                            n.freq = item.counter_freq;
                            n.hits = near ? bump(state_reg.hits) : 2'd0;
                            if (n.hits < CARRIER_HITS) begin
                                restart = 1'b1;
                            end else begin
                                arm          = 1'b1;
                                n            = clear_result(n);
                                n.lock_state = LS_TONE;
                            end
                            n.dwell = dwell_ticks_reg;
                        end else if (state_reg.lock_state == LS_TONE &&
                                     (item.tone_kind == TK_DIGITAL ||
                                      item.tone_kind == TK_TONE)) begin
                            if (item.tone_code != NO_CODE) begin
                                if (item.tone_kind == TK_DIGITAL) begin
                                    n.code       = item.tone_code;
                                    n.code_kind  = TK_DIGITAL;
                                    n.lock_state = LS_FOUND;
                                    n.code_ok    = 1'b1;
                                end else begin
                                    if (item.tone_code == state_reg.code &&
                                        state_reg.code_kind == TK_TONE) begin
                                        n.hits = bump(state_reg.hits);
                                        if (n.hits >= TONE_HITS) begin
                                            n.lock_state = LS_FOUND;
                                            n.code_ok    = 1'b1;
                                        end
                                    end else begin
                                        n.hits = 2'd0;
                                    end
                                    n.code_kind = TK_TONE;
                                    n.code      = item.tone_code;
                                end
                            end
                            if (n.lock_state < LS_FOUND) begin
                                arm     = 1'b1;
                                n.dwell = dwell_ticks_reg;
                            end
                        end
                    end
                end
            end
            ACT_TICK500: begin
                if (item.scan_active && !item.prompt_open &&
                    state_reg.lock_state < LS_FOUND) begin
                    n.progress = 6'(state_reg.progress + 6'd1);
                    if (n.progress > PROGRESS_LIMIT) begin
                        if (state_reg.lock_state == LS_TONE && !state_reg.single_mode) begin
                            n.lock_state = LS_FOUND;
                        end else begin
                            n.lock_state = LS_FAILED;
                        end
                    end
                end
            end
            default: begin
                // unused action code: show the state, no pulses
            end
        endcase
        state_next = n;
    end

    always_comb begin
        result.lock_state      = state_next.lock_state;
        result.locked_freq     = state_next.freq;
        result.found_code      = state_next.code;
        result.found_type      = 2'(state_next.code_kind);
        result.code_valid      = state_next.code_ok;
        result.progress        = state_next.progress;
        result.restart_counter = restart;
        result.arm_tone_scan   = arm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg <= DWELL_RESET;
        end else if (cfg_wr_en) begin
            dwell_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.lock_state  <= LS_CARRIER;
            state_reg.freq        <= ALL_ONES;
            state_reg.hits        <= 2'd0;
            state_reg.code        <= NO_CODE;
            state_reg.code_kind   <= TK_NONE;
            state_reg.code_ok     <= 1'b0;
            state_reg.progress    <= 6'd0;
            state_reg.dwell       <= 8'd0;
            state_reg.single_mode <= 1'b0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ctls_checker.sv =====
`default_nettype none

module ctls_checker
    import ctls_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_lock_state,
    input wire logic [31:0] m_locked_freq,
    input wire logic [7:0]  m_found_code,
    input wire logic [1:0]  m_found_type,
    input wire logic        m_code_valid,
    input wire logic [5:0]  m_progress,
    input wire logic        m_restart_counter,
    input wire logic        m_arm_tone_scan
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lock_state) &&
        $stable(m_locked_freq) && $stable(m_found_code) && $stable(m_progress))
        else $error("stalled result changed");

    // Never re-arm the counter and the tone detector on the same item.
    a_pulses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_restart_counter && m_arm_tone_scan))
        else $error("both pulses on one item");

    // A confirmed code is a recognised code in the found state.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_code_valid |-> m_lock_state == 2'(LS_FOUND) &&
        m_found_code != NO_CODE && m_found_type != 2'(TK_NONE))
        else $error("confirmed code without a lock");

    // Arm the tone detector only when entering or staying in tone search.
    a_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arm_tone_scan |-> m_lock_state == 2'(LS_TONE))
        else $error("tone arm outside tone search");

    // Progress stops once the run has ended.
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_progress <= PROGRESS_MAX)
        else $error("progress past its end");

endmodule

bind carrier_and_tone_lock_sequencer_top ctls_checker u_ctls_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_lock_state      (m_lock_state),
    .m_locked_freq     (m_locked_freq),
    .m_found_code      (m_found_code),
    .m_found_type      (m_found_type),
    .m_code_valid      (m_code_valid),
    .m_progress        (m_progress),
    .m_restart_counter (m_restart_counter),
    .m_arm_tone_scan   (m_arm_tone_scan)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the carrier and tone lock sequencer.
module tb;
    import ctls_pkg::*;

    // Action and tone-kind codes that the package leaves unnamed.
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] TK_UNUSED   = 2'd3;
    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int         QUIET_LIMIT = 2000;
    // Cycles to let pass once the block has gone idle (two-stage pipeline plus margin).
    localparam int         DRAIN_CYCLES = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic        s_single_freq = 1'b0;
    logic [31:0] s_start_freq = '0;
    logic        s_scan_active = 1'b0;
    logic        s_prompt_open = 1'b0;
    logic        s_counter_valid = 1'b0;
    logic [31:0] s_counter_freq = '0;
    logic [1:0]  s_tone_kind = '0;
    logic [7:0]  s_tone_code = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_lock_state;
    logic [31:0] m_locked_freq;
    logic [7:0]  m_found_code;
    logic [1:0]  m_found_type;
    logic        m_code_valid;
    logic [5:0]  m_progress;
    logic        m_restart_counter;
    logic        m_arm_tone_scan;

    carrier_and_tone_lock_sequencer_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_single_freq     (s_single_freq),
        .s_start_freq      (s_start_freq),
        .s_scan_active     (s_scan_active),
        .s_prompt_open     (s_prompt_open),
        .s_counter_valid   (s_counter_valid),
        .s_counter_freq    (s_counter_freq),
        .s_tone_kind       (s_tone_kind),
        .s_tone_code       (s_tone_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lock_state      (m_lock_state),
        .m_locked_freq     (m_locked_freq),
        .m_found_code      (m_found_code),
        .m_found_type      (m_found_type),
        .m_code_valid      (m_code_valid),
        .m_progress        (m_progress),
        .m_restart_counter (m_restart_counter),
        .m_arm_tone_scan   (m_arm_tone_scan)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer shadow: our own copy of the lock state and the dwell setting.
    // ------------------------------------------------------------------
    lock_state_t seq_state;
    logic [31:0] seq_freq;
    logic [1:0]  seq_hits;
    logic [7:0]  seq_code;
    logic [1:0]  seq_code_kind;
    logic        seq_confirmed;
    logic [5:0]  seq_progress;
    logic [7:0]  seq_dwell_left;
    logic        seq_single;
    logic [7:0]  dwell_setting;

    item_t   pending_items[$];     // items waiting to be offered on s_
    result_t expected_reports[$];  // predicted m_ items, oldest first
    int      mismatch_count = 0;
    int      queued_in_phase = 0;

    // Drop any found code and restart the hit and progress counts.
    task automatic clear_found();
        seq_code      = NO_CODE;
        seq_code_kind = TK_NONE;
        seq_confirmed = 1'b0;
        seq_hits      = '0;
        seq_progress  = '0;
    endtask

    // Advance the shadow by one item and return the report it produces.
    task automatic predict_lock_step(input item_t it, output result_t r);
        logic [31:0] diff;
        logic [31:0] span;
        logic        restart;
        logic        arm;
        restart = 1'b0;
        arm     = 1'b0;
        case (it.action)
            ACT_START: begin
                seq_single = it.single_freq;
                if (it.single_freq) begin
                    seq_state = LS_TONE;
                    seq_freq  = it.start_freq;
                    arm       = 1'b1;
                end else begin
                    seq_state = LS_CARRIER;
                    seq_freq  = ALL_ONES;
                    restart   = 1'b1;
                end
                seq_dwell_left = dwell_setting;
                clear_found();
            end
            ACT_TICK10: begin
                if (!it.scan_active) begin
                    // ignored while the scanner is off
                end else if (seq_dwell_left != 0) begin
                    seq_dwell_left = seq_dwell_left - 8'd1;
                end else if (!it.prompt_open) begin
                    if (seq_state == LS_CARRIER && it.counter_valid) begin
                        // Distance the short way round the 32-bit circle.
                        diff = it.counter_freq - seq_freq;
                        span = (diff > HALF_RANGE) ? (32'd0 - diff) : diff;
                        seq_freq = it.counter_freq;
                        if (span < NEAR_LIMIT) begin
                            if (seq_hits < HITS_MAX) seq_hits = seq_hits + 2'd1;
                        end else begin
                            seq_hits = '0;
                        end
                        if (seq_hits < CARRIER_HITS) begin
                            restart = 1'b1;
                        end else begin
                            arm = 1'b1;
                            clear_found();
                            seq_state = LS_TONE;
                        end
                        seq_dwell_left = dwell_setting;
                    end else if (seq_state == LS_TONE &&
                                 (it.tone_kind == TK_DIGITAL || it.tone_kind == TK_TONE)) begin
                        if (it.tone_code != NO_CODE) begin
                            if (it.tone_kind == TK_DIGITAL) begin
                                seq_code      = it.tone_code;
                                seq_code_kind = TK_DIGITAL;
                                seq_state     = LS_FOUND;
                                seq_confirmed = 1'b1;
                            end else begin
                                if (it.tone_code == seq_code && seq_code_kind == TK_TONE) begin
                                    if (seq_hits < HITS_MAX) seq_hits = seq_hits + 2'd1;
                                    if (seq_hits >= TONE_HITS) begin
                                        seq_state     = LS_FOUND;
                                        seq_confirmed = 1'b1;
                                    end
                                end else begin
                                    seq_hits = '0;
                                end
                                seq_code_kind = TK_TONE;
                                seq_code      = it.tone_code;
                            end
                        end
                        if (seq_state == LS_CARRIER || seq_state == LS_TONE) begin
                            arm            = 1'b1;
                            seq_dwell_left = dwell_setting;
                        end
                    end
                end
            end
            ACT_TICK500: begin
                if (it.scan_active && !it.prompt_open &&
                    (seq_state == LS_CARRIER || seq_state == LS_TONE)) begin
                    seq_progress = seq_progress + 6'd1;
                    if (seq_progress > PROGRESS_LIMIT) begin
                        if (seq_state == LS_TONE && !seq_single) seq_state = LS_FOUND;
                        else seq_state = LS_FAILED;
                    end
                end
            end
            default: begin
                // unused action: state holds, no pulses
            end
        endcase
        r.lock_state      = seq_state;
        r.locked_freq     = seq_freq;
        r.found_code      = seq_code;
        r.found_type      = seq_code_kind;
        r.code_valid      = seq_confirmed;
        r.progress        = seq_progress;
        r.restart_counter = restart;
        r.arm_tone_scan   = arm;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input item_t it);
        pending_items.push_back(it);
        queued_in_phase++;
    endtask

    function automatic item_t random_item();
        item_t it;
        it.action        = 2'($urandom_range(0, 3));
        it.single_freq   = 1'($urandom());
        it.start_freq    = $urandom();
        it.scan_active   = 1'($urandom());
        it.prompt_open   = 1'($urandom());
        it.counter_valid = 1'($urandom());
        it.counter_freq  = $urandom();
        it.tone_kind     = 2'($urandom());
        it.tone_code     = 8'($urandom());
        return it;
    endfunction

    function automatic item_t tick10(input logic cvalid, input logic [31:0] cfreq,
                                     input logic [1:0] kind, input logic [7:0] code);
        item_t it;
        it               = '0;
        it.action        = ACT_TICK10;
        it.scan_active   = 1'b1;
        it.counter_valid = cvalid;
        it.counter_freq  = cfreq;
        it.tone_kind     = kind;
        it.tone_code     = code;
        return it;
    endfunction

    function automatic item_t start_run(input logic single, input logic [31:0] freq);
        item_t it;
        it             = '0;
        it.action      = ACT_START;
        it.single_freq = single;
        it.start_freq  = freq;
        return it;
    endfunction

    // Queue one scan run: a start, then ticks whose readings hover around a
    // carrier and whose tone codes mostly repeat, so the run can lock and find.
    // Some runs stay silent on tones and end in a timeout on the progress count.
    task automatic queue_lock_run();
        item_t       it;
        logic [31:0] carrier;
        logic [7:0]  tone;
        bit          run_out;
        int          ticks;
        int          roll;
        it = random_item();
        it.action = ACT_START;
        it.single_freq = ($urandom_range(0, 3) == 0);
        push_item(it);
        // A carrier near zero sits within reach of the all-ones start frequency.
        carrier = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 160)) : $urandom();
        tone    = 8'($urandom_range(0, 254));
        run_out = ($urandom_range(0, 5) == 0);
        ticks   = int'(dwell_setting) * 3 / 2 + $urandom_range(15, 60);
        repeat (ticks) begin
            it = random_item();
            it.action        = ($urandom_range(0, 99) < 85) ? ACT_TICK10 : ACT_TICK500;
            it.scan_active   = ($urandom_range(0, 19) != 0);
            it.prompt_open   = ($urandom_range(0, 11) == 0);
            it.counter_valid = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) != 0)
                it.counter_freq = carrier + 32'($urandom_range(0, 140)) - 32'd70;
            if ($urandom_range(0, 19) == 0) tone = 8'($urandom_range(0, 254));
            roll = $urandom_range(0, 99);
            if (run_out) it.tone_kind = TK_NONE;
            else if (roll < 60) it.tone_kind = TK_TONE;
            else if (roll < 70) it.tone_kind = TK_DIGITAL;
            else if (roll < 85) it.tone_kind = TK_NONE;
            else it.tone_kind = TK_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 75) it.tone_code = tone;
            else if (roll < 85) it.tone_code = NO_CODE;
            push_item(it);
        end
        if (run_out) begin
            repeat ($urandom_range(33, 36)) begin
                it = random_item();
                it.action      = ACT_TICK500;
                it.scan_active = 1'b1;
                it.prompt_open = 1'b0;
                push_item(it);
            end
        end
    endtask

    // Hold until every queued item has gone in and every report has come out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write dwell_ticks while the block is idle; the shadow follows at once.
    task automatic write_dwell(input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dwell_setting = value;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued items on s_, with random gaps and calm stretches.
    // ------------------------------------------------------------------
    item_t   offered;
    result_t predicted;
    int      tx_gap = 0;
    int      tx_calm = 0;
    int      tx_roll;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Predict at the edge where the block takes the item.
            if (s_valid && s_ready) begin
                predict_lock_step(offered, predicted);
                expected_reports.push_back(predicted);
            end
            if (s_valid && !s_ready) begin
                // hold the item until it is taken
            end else if (tx_gap != 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                offered = pending_items.pop_front();
                s_action        <= offered.action;
                s_single_freq   <= offered.single_freq;
                s_start_freq    <= offered.start_freq;
                s_scan_active   <= offered.scan_active;
                s_prompt_open   <= offered.prompt_open;
                s_counter_valid <= offered.counter_valid;
                s_counter_freq  <= offered.counter_freq;
                s_tone_kind     <= offered.tone_kind;
                s_tone_code     <= offered.tone_code;
                s_valid         <= 1'b1;
                // Pick the gap that follows this item: mostly none, a few long.
                tx_roll = $urandom_range(0, 999);
                if (tx_calm != 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else if (tx_roll < 10) begin
                    tx_calm = $urandom_range(40, 120);
                    tx_gap = 0;
                end else if (tx_roll < 550) begin
                    tx_gap = 0;
                end else if (tx_roll < 900) begin
                    tx_gap = $urandom_range(1, 3);
                end else if (tx_roll < 980) begin
                    tx_gap = $urandom_range(4, 10);
                end else begin
                    tx_gap = $urandom_range(20, 50);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure on m_, plus one long hold-off while the
    // sender still has plenty queued, so both pipeline stages fill and s_ready drops.
    // ------------------------------------------------------------------
    int rx_stall = 0;
    int rx_calm = 0;
    int rx_roll;
    bit pressure_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else if (!pressure_done && pending_items.size() > 40) begin
            pressure_done = 1'b1;
            rx_stall = 150;
            m_ready <= 1'b0;
        end else if (rx_calm != 0) begin
            rx_calm--;
            m_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 999);
            if (rx_roll < 10) begin
                rx_calm = $urandom_range(40, 120);
                m_ready <= 1'b1;
            end else if (rx_roll < 700) begin
                m_ready <= 1'b1;
            end else if (rx_roll < 980) begin
                rx_stall = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                rx_stall = $urandom_range(10, 60);
                m_ready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each report taken on m_ with the oldest prediction.
    // ------------------------------------------------------------------
    result_t oldest;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("report on m_ with no item outstanding");
                mismatch_count++;
            end else begin
                oldest = expected_reports.pop_front();
                check_field("lock_state", 32'(oldest.lock_state), 32'(m_lock_state));
                check_field("locked_freq", oldest.locked_freq, m_locked_freq);
                check_field("found_code", 32'(oldest.found_code), 32'(m_found_code));
                check_field("found_type", 32'(oldest.found_type), 32'(m_found_type));
                check_field("code_valid", 32'(oldest.code_valid), 32'(m_code_valid));
                check_field("progress", 32'(oldest.progress), 32'(m_progress));
                check_field("restart_counter", 32'(oldest.restart_counter),
                            32'(m_restart_counter));
                check_field("arm_tone_scan", 32'(oldest.arm_tone_scan),
                            32'(m_arm_tone_scan));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abandon the run if no item moves for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("carrier_and_tone_lock_sequencer_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [7:0] dwell_plan [8] = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd10, 8'd3, 8'd0, 8'd7};

    initial begin
        item_t       it;
        logic [31:0] rd;
        int          budget;

        // Shadow starts from the reset state.
        dwell_setting  = DWELL_RESET;
        seq_state      = LS_CARRIER;
        seq_freq       = ALL_ONES;
        seq_dwell_left = '0;
        seq_single     = 1'b0;
        clear_found();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, no dwell so every tick acts.
        write_dwell(8'd0);
        it = '1;                                          // unused action, all bits high
        it.action = ACT_UNUSED;
        push_item(it);
        it = tick10(1'b1, 32'd0, TK_TONE, 8'd1);          // scanner off: ignored
        it.scan_active = 1'b0;
        push_item(it);
        push_item(start_run(1'b0, ALL_ONES));             // sweep from all ones
        push_item(tick10(1'b1, 32'd0, TK_NONE, NO_CODE)); // wraps to within one of all ones
        push_item(tick10(1'b1, 32'd98, TK_NONE, NO_CODE));
        it = tick10(1'b1, 32'd500, TK_NONE, NO_CODE);     // save prompt pauses the read
        it.prompt_open = 1'b1;
        push_item(it);
        push_item(tick10(1'b0, 32'd7, TK_NONE, NO_CODE)); // no new reading
        rd = 32'd98 + HALF_RANGE;                         // exactly half way round: far
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        rd = rd - 32'd99;                                 // near, going down
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        rd = rd + 32'd100;                                // right at the limit: far
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        rd = rd + 32'd99;
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        rd = rd - 32'd50;                                 // third hit locks
        push_item(tick10(1'b1, rd, TK_NONE, NO_CODE));
        it = tick10(1'b0, 32'd0, TK_NONE, NO_CODE);
        it.action = ACT_TICK500;
        push_item(it);
        push_item(tick10(1'b0, 32'd0, TK_UNUSED, 8'd5));  // unused kind: no detection
        push_item(tick10(1'b0, 32'd0, TK_TONE, NO_CODE)); // unrecognised: re-arm only
        push_item(tick10(1'b0, 32'd0, TK_DIGITAL, NO_CODE));
        push_item(tick10(1'b0, 32'd0, TK_TONE, 8'd5));
        push_item(tick10(1'b0, 32'd0, TK_TONE, 8'd5));
        push_item(tick10(1'b0, 32'd0, TK_TONE, 8'd7));    // code changed: count restarts
        push_item(tick10(1'b0, 32'd0, TK_TONE, 8'd7));
        push_item(tick10(1'b0, 32'd0, TK_TONE, 8'd7));
        it = tick10(1'b0, 32'd0, TK_NONE, NO_CODE);       // found: progress stops
        it.action = ACT_TICK500;
        push_item(it);
        push_item(start_run(1'b1, 32'h1234_5678));
        push_item(tick10(1'b0, 32'd0, TK_DIGITAL, 8'd0));
        push_item(start_run(1'b1, 32'd0));
        it = tick10(1'b0, 32'd0, TK_NONE, NO_CODE);
        it.action = ACT_TICK500;
        it.prompt_open = 1'b1;
        push_item(it);
        wait_drained();

        // Random phases, one dwell setting each; the longest dwell gets a larger item budget.
        foreach (dwell_plan[p]) begin
            write_dwell(dwell_plan[p]);
            budget = (dwell_plan[p] > 8'd100) ? 400 : 190;
            queued_in_phase = 0;
            while (queued_in_phase < budget) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_lock_run();
                end else begin
                    repeat ($urandom_range(1, 20)) push_item(random_item());
                end
            end
            wait_drained();
        end

        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("carrier_and_tone_lock_sequencer_top: match");
        end else begin
            $display("carrier_and_tone_lock_sequencer_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ctls_pkg.sv
hdl/ctls_core.sv
hdl/carrier_and_tone_lock_sequencer_top.sv
hdl/ctls_checker.sv
test/tb.sv
